// ===== rtl/core/bfu_pkg.sv =====
// ----------------------------------------------------------------------------
// bfu_pkg
// Shared types, register indexes, widths and constants of the boid update.
// ----------------------------------------------------------------------------
package bfu_pkg;

    localparam int MAX_BOIDS_DEF = 64;

    // register indexes of the configuration port
    localparam logic [2:0] REG_BOID_COUNT     = 3'd0;
    localparam logic [2:0] REG_AVOID_DISTANCE = 3'd1;
    localparam logic [2:0] REG_CENTER_RANGE   = 3'd2;
    localparam logic [2:0] REG_CENTER_GAIN    = 3'd3;
    localparam logic [2:0] REG_FOLLOW_GAIN    = 3'd4;
    localparam logic [2:0] REG_AVOID_GAIN     = 3'd5;
    localparam logic [2:0] REG_MAX_SPEED      = 3'd6;
    localparam logic [2:0] REG_MIN_SPEED      = 3'd7;

    // function codes (code 3 behaves as a read)
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_UPDATE = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    // walls in Q3.13: 0.97 and 1.2
    localparam logic signed [15:0] WALL_NEAR = 16'sd7946;
    localparam logic signed [15:0] WALL_FAR  = 16'sd9830;
    localparam int WALL_PUSH = 82;

    // datapath widths
    localparam int V_W   = 26;      // wide velocity accumulator
    localparam int DVD_W = 48;      // divider dividend
    localparam int DVS_W = 26;      // divider divisor
    localparam int Q_W   = 20;      // divider quotient bits
    localparam int RT_W  = 26;      // square root result
    localparam int S2_W  = 2 * RT_W;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_CAP,
        ST_SELF_CAP,
        ST_SCAN,
        ST_T_MUL1,
        ST_T_MUL2,
        ST_T_DIV,
        ST_T_WAIT,
        ST_SEP_MUL,
        ST_SEP_ADD,
        ST_SPD_MUL,
        ST_SPD_CMP,
        ST_SQRT_WAIT,
        ST_CL_MUL,
        ST_CL_DIV,
        ST_CL_WAIT,
        ST_WALL,
        ST_DONE
    } bfu_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
    } boid_t;

endpackage

// ===== rtl/core/bfu_div.sv =====
// ----------------------------------------------------------------------------
// bfu_div
// Restoring unsigned divider, one quotient bit per cycle.
// The quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
module bfu_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [bfu_pkg::DVD_W-1:0] dividend,
    input  logic [bfu_pkg::DVS_W-1:0] divisor,
    output logic [bfu_pkg::Q_W-1:0]   quotient,
    output bfu_pkg::unit_stat_t       stat
);
    import bfu_pkg::*;

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DVD_W-1:0] rem_reg;
    logic [DVD_W-1:0] dvs_reg;
    logic [Q_W-1:0]   q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             fit;

    assign fit = rem_reg >= dvs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dvs_reg <= DVD_W'(divisor) << (Q_W - 1);
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (fit) begin
                rem_reg <= rem_reg - dvs_reg;
            end
            q_reg   <= {q_reg[Q_W-2:0], fit};
            dvs_reg <= dvs_reg >> 1;
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/core/bfu_sqrt.sv =====
// ----------------------------------------------------------------------------
// bfu_sqrt
// Integer square root (floor), digit by digit, one result bit per cycle.
// ----------------------------------------------------------------------------
module bfu_sqrt (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [bfu_pkg::S2_W-1:0] radicand,
    output logic [bfu_pkg::RT_W-1:0] root,
    output bfu_pkg::unit_stat_t      stat
);
    import bfu_pkg::*;

    localparam int CNT_W = $clog2(RT_W + 1);

    logic [S2_W-1:0]  v_reg;
    logic [RT_W+1:0]  rem_reg;
    logic [RT_W-1:0]  root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [RT_W+1:0]  rem_sh;
    logic [RT_W+1:0]  trial;
    logic             fit;

    assign rem_sh = {rem_reg[RT_W-1:0], v_reg[S2_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fit    = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(RT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            v_reg    <= v_reg << 2;
            rem_reg  <= fit ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[RT_W-2:0], fit};
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/core/boid_flocking_update.sv =====
// ----------------------------------------------------------------------------
// boid_flocking_update
// Boid table in a synchronous RAM with load, read and in-place flocking update.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | func, index, load position/velocity
//  m_      | out       | m_valid / m_ready    | index, new position/velocity, flags
//  cfg_    | in        | cfg_we (no wait)     | cfg_addr, cfg_wdata
//
// Load and out-of-range items go straight to the output register; a read
// first captures the table word. An update scans the table (one RAM read a
// cycle), runs four averaging divisions through the shared bit-serial
// divider when neighbors exist, and on a speed clamp a square root plus two
// divisions. One item is in flight at a time; the next beat is taken once
// the result sits in the output register. A stalled output holds the
// finished item. Synchronous reset, no table clearing.
// ----------------------------------------------------------------------------
module boid_flocking_update #(
    parameter int MAX_BOIDS = bfu_pkg::MAX_BOIDS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [5:0]         s_boid_index,
    input  logic signed [15:0] s_load_pos_x,
    input  logic signed [15:0] s_load_pos_y,
    input  logic signed [15:0] s_load_vel_x,
    input  logic signed [15:0] s_load_vel_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_entry_index,
    output logic signed [15:0] m_new_pos_x,
    output logic signed [15:0] m_new_pos_y,
    output logic signed [15:0] m_new_vel_x,
    output logic signed [15:0] m_new_vel_y,
    output logic [6:0]         m_neighbours_seen,
    output logic               m_wall_reset,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata
);
    import bfu_pkg::*;

    localparam int IDX_W = (MAX_BOIDS > 1) ? $clog2(MAX_BOIDS) : 1;
    localparam logic signed [V_W-1:0] SAT_HI = V_W'(32767);
    localparam logic signed [V_W-1:0] SAT_LO = -SAT_HI - V_W'(1);

    function automatic logic signed [15:0] sat16(input logic signed [V_W-1:0] v);
        logic signed [15:0] r;
        if (v > SAT_HI) r = 16'sh7fff;
        else if (v < SAT_LO) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction

    // round to nearest of v / 65536, ties away from zero
    function automatic logic signed [V_W-1:0] rnd16(input logic signed [39:0] v);
        logic [39:0] mag;
        logic [23:0] q;
        mag = v[39] ? 40'(-v) : 40'(v);
        q   = 24'((mag + 40'd32768) >> 16);
        return v[39] ? -$signed(V_W'(q)) : $signed(V_W'(q));
    endfunction

    // configuration
    logic [6:0]  boid_count_reg;
    logic [14:0] avoid_dist_reg, cent_range_reg, max_speed_reg, min_speed_reg;
    logic [15:0] cent_gain_reg, follow_gain_reg, avoid_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boid_count_reg  <= 7'd64;
            avoid_dist_reg  <= 15'd410;
            cent_range_reg  <= 15'd1638;
            cent_gain_reg   <= 16'd33;
            follow_gain_reg <= 16'd3277;
            avoid_gain_reg  <= 16'd3277;
            max_speed_reg   <= 15'd82;
            min_speed_reg   <= 15'd16;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_BOID_COUNT:     boid_count_reg  <= cfg_wdata[6:0];
                REG_AVOID_DISTANCE: avoid_dist_reg  <= cfg_wdata[14:0];
                REG_CENTER_RANGE:   cent_range_reg  <= cfg_wdata[14:0];
                REG_CENTER_GAIN:    cent_gain_reg   <= cfg_wdata;
                REG_FOLLOW_GAIN:    follow_gain_reg <= cfg_wdata;
                REG_AVOID_GAIN:     avoid_gain_reg  <= cfg_wdata;
                REG_MAX_SPEED:      max_speed_reg   <= cfg_wdata[14:0];
                REG_MIN_SPEED:      min_speed_reg   <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // state and datapath registers
    bfu_state_t state_reg, state_next;

    logic [5:0]  idx_reg;
    logic [6:0]  cnt_reg, rd_cnt_reg, n_reg;
    logic signed [15:0] x_reg, y_reg;
    logic signed [V_W-1:0] vx_reg, vy_reg;
    logic [29:0] ad2_reg, cr2_reg, max2_reg, min2_reg;
    logic        p1_valid_reg, s2_valid_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic [33:0] dx2_reg, dy2_reg;
    logic signed [15:0] o_px_reg, o_py_reg, o_vx_reg, o_vy_reg;
    logic signed [22:0] mx_reg, my_reg;
    logic signed [21:0] sx_reg, sy_reg, svx_reg, svy_reg;
    logic [1:0]  term_reg;
    logic signed [33:0] nprod_reg;
    logic signed [44:0] prod_reg;
    logic signed [39:0] sepx_reg, sepy_reg;
    logic [S2_W-1:0] sqx_reg, sqy_reg;
    logic [14:0] clamp_reg;
    logic [RT_W-1:0] spd_reg;
    logic        axis_reg;
    logic signed [V_W+15:0] clp_reg;

    // result and output registers
    logic [5:0]  res_idx_reg;
    boid_t       res_boid_reg;
    logic [6:0]  res_seen_reg;
    logic        res_wreset_reg;
    logic        m_valid_reg;
    logic [5:0]  m_idx_reg;
    boid_t       m_boid_reg;
    logic [6:0]  m_seen_reg;
    logic        m_wreset_reg;

    // table memory
    boid_t             mem [MAX_BOIDS];
    boid_t             mem_q;
    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    boid_t             mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) mem_q <= mem[mem_raddr];
    end

    // shared units
    logic             div_start, sqrt_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic [Q_W-1:0]   div_q;
    unit_stat_t       div_stat, sqrt_stat;
    logic [RT_W-1:0]  sqrt_root;

    bfu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .stat     (div_stat)
    );

    bfu_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqx_reg + sqy_reg),
        .root     (sqrt_root),
        .stat     (sqrt_stat)
    );

    // combinational helpers
    logic        accept, in_rng, scan_issue, scan_end;
    logic [6:0]  cnt_lim;
    logic signed [V_W-1:0] self_sel, v_axis, qext;
    logic signed [33:0] sum_sel;
    logic signed [33:0] diff;
    logic [15:0] gain_sel;
    logic [44:0] prod_mag;
    logic [V_W+15:0] clp_mag;
    logic [S2_W-1:0] s2;
    logic        gt_max, lt_min;
    logic [34:0] d2;
    logic signed [V_W-1:0] vxw, vyw, pxb, pyb;
    logic signed [15:0] vxs, vys;
    logic        wreset;

    assign accept  = s_valid && s_ready;
    assign in_rng  = {1'b0, s_boid_index} < 7'(MAX_BOIDS);
    assign cnt_lim = (boid_count_reg > 7'(MAX_BOIDS)) ? 7'(MAX_BOIDS) : boid_count_reg;
    assign scan_issue = (state_reg == ST_SCAN) && (rd_cnt_reg < cnt_reg);
    assign scan_end   = (state_reg == ST_SCAN) && (rd_cnt_reg == cnt_reg)
                        && !p1_valid_reg && !s2_valid_reg;
    assign d2 = {1'b0, dx2_reg} + {1'b0, dy2_reg};

    always_comb begin
        case (term_reg)
            2'd0: begin
                self_sel = V_W'(x_reg);
                sum_sel  = 34'(sx_reg);
                gain_sel = cent_gain_reg;
            end
            2'd1: begin
                self_sel = V_W'(y_reg);
                sum_sel  = 34'(sy_reg);
                gain_sel = cent_gain_reg;
            end
            2'd2: begin
                self_sel = vx_reg;
                sum_sel  = 34'(svx_reg);
                gain_sel = follow_gain_reg;
            end
            default: begin
                self_sel = vy_reg;
                sum_sel  = 34'(svy_reg);
                gain_sel = follow_gain_reg;
            end
        endcase
    end

    assign diff     = sum_sel - nprod_reg;
    assign prod_mag = prod_reg[44] ? 45'(-prod_reg) : 45'(prod_reg);
    assign v_axis   = axis_reg ? vy_reg : vx_reg;
    assign clp_mag  = clp_reg[V_W+15] ? (V_W+16)'(-clp_reg) : (V_W+16)'(clp_reg);
    assign qext     = $signed(V_W'(div_q));
    assign s2       = sqx_reg + sqy_reg;
    assign gt_max   = s2 > S2_W'(max2_reg);
    assign lt_min   = (s2 != '0) && (s2 < S2_W'(min2_reg));

    // walls, origin reset, position step
    always_comb begin
        vxw = vx_reg;
        vyw = vy_reg;
        if (x_reg < -WALL_NEAR) vxw = vx_reg + V_W'(WALL_PUSH);
        else if (x_reg > WALL_NEAR) vxw = vx_reg - V_W'(WALL_PUSH);
        if (y_reg < -WALL_NEAR) vyw = vy_reg + V_W'(WALL_PUSH);
        else if (y_reg > WALL_NEAR) vyw = vy_reg - V_W'(WALL_PUSH);
        vxs = sat16(vxw);
        vys = sat16(vyw);
        wreset = (x_reg > WALL_FAR) || (x_reg < -WALL_FAR)
                 || (y_reg > WALL_FAR) || (y_reg < -WALL_FAR);
        pxb = wreset ? '0 : V_W'(x_reg);
        pyb = wreset ? '0 : V_W'(y_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!in_rng || s_func == FUNC_LOAD) state_next = ST_DONE;
                    else if (s_func == FUNC_UPDATE) state_next = ST_SELF_CAP;
                    else state_next = ST_RD_CAP;
                end
            end
            ST_RD_CAP:   state_next = ST_DONE;
            ST_SELF_CAP: state_next = ST_SCAN;
            ST_SCAN: begin
                if (scan_end) state_next = (n_reg == '0) ? ST_SEP_MUL : ST_T_MUL1;
            end
            ST_T_MUL1: state_next = ST_T_MUL2;
            ST_T_MUL2: state_next = ST_T_DIV;
            ST_T_DIV:  state_next = ST_T_WAIT;
            ST_T_WAIT: begin
                if (div_stat.done) begin
                    state_next = (term_reg == 2'd3) ? ST_SEP_MUL : ST_T_MUL1;
                end
            end
            ST_SEP_MUL: state_next = ST_SEP_ADD;
            ST_SEP_ADD: state_next = ST_SPD_MUL;
            ST_SPD_MUL: state_next = ST_SPD_CMP;
            ST_SPD_CMP: state_next = (gt_max || lt_min) ? ST_SQRT_WAIT : ST_WALL;
            ST_SQRT_WAIT: begin
                if (sqrt_stat.done) state_next = ST_CL_MUL;
            end
            ST_CL_MUL: state_next = ST_CL_DIV;
            ST_CL_DIV: state_next = ST_CL_WAIT;
            ST_CL_WAIT: begin
                if (div_stat.done) state_next = axis_reg ? ST_WALL : ST_CL_MUL;
            end
            ST_WALL: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready      = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = s_boid_index[IDX_W-1:0];
        mem_raddr    = s_boid_index[IDX_W-1:0];
        mem_wdata    = '{px: s_load_pos_x, py: s_load_pos_y,
                         vx: s_load_vel_x, vy: s_load_vel_y};
        div_start    = 1'b0;
        div_dividend = DVD_W'(prod_mag) + DVD_W'({n_reg, 15'd0});
        div_divisor  = DVS_W'({n_reg, 16'd0});
        sqrt_start   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                mem_we  = accept && in_rng && (s_func == FUNC_LOAD);
                mem_re  = accept && in_rng && (s_func != FUNC_LOAD);
            end
            ST_SCAN: begin
                mem_re    = scan_issue;
                mem_raddr = rd_cnt_reg[IDX_W-1:0];
            end
            ST_T_DIV: div_start = 1'b1;
            ST_SPD_CMP: sqrt_start = gt_max || lt_min;
            ST_CL_DIV: begin
                div_start    = 1'b1;
                div_dividend = DVD_W'(clp_mag) + DVD_W'(spd_reg >> 1);
                div_divisor  = DVS_W'(spd_reg);
            end
            ST_WALL: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[IDX_W-1:0];
                mem_wdata = '{px: sat16(pxb + V_W'(vxs)), py: sat16(pyb + V_W'(vys)),
                              vx: vxs, vy: vys};
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            p1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            n_reg        <= '0;
            rd_cnt_reg   <= '0;
            term_reg     <= '0;
            axis_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            p1_valid_reg <= scan_issue;
            s2_valid_reg <= p1_valid_reg;
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            if (accept) cnt_reg <= cnt_lim;
            if (state_reg == ST_SELF_CAP) begin
                rd_cnt_reg <= '0;
                n_reg      <= '0;
                term_reg   <= '0;
                axis_reg   <= 1'b0;
            end
            if (scan_issue) rd_cnt_reg <= rd_cnt_reg + 7'd1;
            if (s2_valid_reg && d2 < 35'(cr2_reg)) n_reg <= n_reg + 7'd1;
            if (state_reg == ST_T_WAIT && div_stat.done) term_reg <= term_reg + 2'd1;
            if (state_reg == ST_CL_WAIT && div_stat.done) axis_reg <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg        <= s_boid_index;
            res_idx_reg    <= s_boid_index;
            res_seen_reg   <= '0;
            res_wreset_reg <= 1'b0;
            if (!in_rng) res_boid_reg <= '0;
            else res_boid_reg <= '{px: s_load_pos_x, py: s_load_pos_y,
                                   vx: s_load_vel_x, vy: s_load_vel_y};
        end
        if (state_reg == ST_RD_CAP) res_boid_reg <= mem_q;
        if (state_reg == ST_SELF_CAP) begin
            x_reg    <= mem_q.px;
            y_reg    <= mem_q.py;
            vx_reg   <= V_W'(mem_q.vx);
            vy_reg   <= V_W'(mem_q.vy);
            ad2_reg  <= avoid_dist_reg * avoid_dist_reg;
            cr2_reg  <= cent_range_reg * cent_range_reg;
            max2_reg <= max_speed_reg * max_speed_reg;
            min2_reg <= min_speed_reg * min_speed_reg;
            mx_reg   <= '0;
            my_reg   <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            svx_reg  <= '0;
            svy_reg  <= '0;
        end
        // scan stage 2: offsets and squares
        if (p1_valid_reg) begin
            dx_reg   <= 17'(mem_q.px) - 17'(x_reg);
            dy_reg   <= 17'(mem_q.py) - 17'(y_reg);
            dx2_reg  <= 34'((17'(mem_q.px) - 17'(x_reg)) * (17'(mem_q.px) - 17'(x_reg)));
            dy2_reg  <= 34'((17'(mem_q.py) - 17'(y_reg)) * (17'(mem_q.py) - 17'(y_reg)));
            o_px_reg <= mem_q.px;
            o_py_reg <= mem_q.py;
            o_vx_reg <= mem_q.vx;
            o_vy_reg <= mem_q.vy;
        end
        // scan stage 3: accumulate
        if (s2_valid_reg) begin
            if (d2 < 35'(ad2_reg)) begin
                mx_reg <= mx_reg - 23'(dx_reg);
                my_reg <= my_reg - 23'(dy_reg);
            end
            if (d2 < 35'(cr2_reg)) begin
                sx_reg  <= sx_reg + 22'(o_px_reg);
                sy_reg  <= sy_reg + 22'(o_py_reg);
                svx_reg <= svx_reg + 22'(o_vx_reg);
                svy_reg <= svy_reg + 22'(o_vy_reg);
            end
        end
        if (state_reg == ST_T_MUL1) nprod_reg <= $signed({1'b0, n_reg}) * self_sel;
        if (state_reg == ST_T_MUL2) prod_reg <= $signed(diff[27:0]) * $signed({1'b0, gain_sel});
        if (state_reg == ST_T_WAIT && div_stat.done) begin
            if (!term_reg[0]) vx_reg <= prod_reg[44] ? vx_reg - qext : vx_reg + qext;
            else vy_reg <= prod_reg[44] ? vy_reg - qext : vy_reg + qext;
        end
        if (state_reg == ST_SEP_MUL) begin
            sepx_reg <= mx_reg * $signed({1'b0, avoid_gain_reg});
            sepy_reg <= my_reg * $signed({1'b0, avoid_gain_reg});
        end
        if (state_reg == ST_SEP_ADD) begin
            vx_reg <= vx_reg + rnd16(sepx_reg);
            vy_reg <= vy_reg + rnd16(sepy_reg);
        end
        if (state_reg == ST_SPD_MUL) begin
            sqx_reg <= $unsigned(S2_W'(vx_reg * vx_reg));
            sqy_reg <= $unsigned(S2_W'(vy_reg * vy_reg));
        end
        if (state_reg == ST_SPD_CMP) clamp_reg <= gt_max ? max_speed_reg : min_speed_reg;
        if (state_reg == ST_SQRT_WAIT && sqrt_stat.done) spd_reg <= sqrt_root;
        if (state_reg == ST_CL_MUL) clp_reg <= v_axis * $signed({1'b0, clamp_reg});
        if (state_reg == ST_CL_WAIT && div_stat.done) begin
            if (!axis_reg) vx_reg <= clp_reg[V_W+15] ? -qext : qext;
            else vy_reg <= clp_reg[V_W+15] ? -qext : qext;
        end
        if (state_reg == ST_WALL) begin
            res_boid_reg   <= mem_wdata;
            res_seen_reg   <= n_reg;
            res_wreset_reg <= wreset;
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_idx_reg    <= res_idx_reg;
            m_boid_reg   <= res_boid_reg;
            m_seen_reg   <= res_seen_reg;
            m_wreset_reg <= res_wreset_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_entry_index     = m_idx_reg;
    assign m_new_pos_x       = m_boid_reg.px;
    assign m_new_pos_y       = m_boid_reg.py;
    assign m_new_vel_x       = m_boid_reg.vx;
    assign m_new_vel_y       = m_boid_reg.vy;
    assign m_neighbours_seen = m_seen_reg;
    assign m_wall_reset      = m_wreset_reg;

    // table writes only from a load beat or the final update step
    a_mem_we_src: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_IDLE || state_reg == ST_WALL))
        else $error("table write outside load or update write-back");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_sqrt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_start |-> !sqrt_stat.busy)
        else $error("square root restarted while busy");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && mem_re) |-> (rd_cnt_reg < cnt_reg))
        else $error("scan read past active count");

    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SPD_MUL) |-> (n_reg <= cnt_reg))
        else $error("neighbor count above scanned count");

endmodule

// ===== tb/boid_flocking_update_test.sv =====
// ----------------------------------------------------------------------------
// boid_flocking_update_test
// Self-checking bench for the boid table: loads, reads and flocking updates
// are sent with bursty valid and random result stalls. A behavioral copy of
// the table predicts every result beat, compared as a whole result word.
// ----------------------------------------------------------------------------
module boid_flocking_update_test;
    import bfu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = 64;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_func;
    logic [5:0]         s_boid_index;
    logic signed [15:0] s_load_pos_x, s_load_pos_y, s_load_vel_x, s_load_vel_y;
    logic               m_valid;
    logic               m_ready;
    logic [5:0]         m_entry_index;
    logic signed [15:0] m_new_pos_x, m_new_pos_y, m_new_vel_x, m_new_vel_y;
    logic [6:0]         m_neighbours_seen;
    logic               m_wall_reset;
    logic               cfg_we;
    logic [2:0]         cfg_addr;
    logic [15:0]        cfg_wdata;

    boid_flocking_update dut (.*);

    typedef struct packed {
        logic [5:0]         idx;
        logic signed [15:0] px, py, vx, vy;
        logic [6:0]         seen;
        logic               wrst;
    } flock_result_t;

    // predictor state
    longint tbl_px[NB], tbl_py[NB], tbl_vx[NB], tbl_vy[NB];
    longint r_count, r_avoid, r_range, r_cgain, r_fgain, r_again, r_vmax, r_vmin;

    flock_result_t expected_q[$];
    int     mismatches;
    longint cycles = 0;
    int     gap_left;
    bit     burst_on;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3_000_000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint round_div(longint num, longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint wall_push(longint p, longint v);
        if (p < -7946) return v + WALL_PUSH;
        if (p > 7946) return v - WALL_PUSH;
        return v;
    endfunction

    function automatic flock_result_t flock_step(logic [1:0] fn, logic [5:0] i,
                                                 logic signed [15:0] lpx,
                                                 logic signed [15:0] lpy,
                                                 logic signed [15:0] lvx,
                                                 logic signed [15:0] lvy);
        flock_result_t r;
        longint x, y, vx, vy, mx, my, sx, sy, svx, svy, n, den, s, cnt, dx, dy, d2;
        longint unsigned s2;
        r = '0;
        r.idx = i;
        if (fn == FUNC_LOAD) begin
            tbl_px[i] = lpx; tbl_py[i] = lpy; tbl_vx[i] = lvx; tbl_vy[i] = lvy;
        end else if (fn == FUNC_UPDATE) begin
            cnt = r_count > NB ? NB : r_count;
            x = tbl_px[i]; y = tbl_py[i]; vx = tbl_vx[i]; vy = tbl_vy[i];
            mx = 0; my = 0; sx = 0; sy = 0; svx = 0; svy = 0; n = 0;
            for (int j = 0; j < cnt; j++) begin
                dx = tbl_px[j] - x;
                dy = tbl_py[j] - y;
                d2 = dx * dx + dy * dy;
                if (d2 < r_avoid * r_avoid) begin
                    mx -= dx; my -= dy;
                end
                if (d2 < r_range * r_range) begin
                    svx += tbl_vx[j]; svy += tbl_vy[j];
                    sx += tbl_px[j]; sy += tbl_py[j];
                    n++;
                end
            end
            if (n > 0) begin
                den = n * 65536;
                vx += round_div((sx - n * x) * r_cgain, den);
                vy += round_div((sy - n * y) * r_cgain, den);
                vx += round_div((svx - n * vx) * r_fgain, den);
                vy += round_div((svy - n * vy) * r_fgain, den);
            end
            vx += round_div(mx * r_again, 65536);
            vy += round_div(my * r_again, 65536);
            s2 = vx * vx + vy * vy;
            if (s2 > r_vmax * r_vmax) begin
                s = int_sqrt(s2);
                vx = round_div(vx * r_vmax, s);
                vy = round_div(vy * r_vmax, s);
            end else if (s2 != 0 && s2 < r_vmin * r_vmin) begin
                s = int_sqrt(s2);
                vx = round_div(vx * r_vmin, s);
                vy = round_div(vy * r_vmin, s);
            end
            vx = sat16(wall_push(x, vx));
            vy = sat16(wall_push(y, vy));
            if (x > 9830 || x < -9830 || y > 9830 || y < -9830) begin
                x = 0; y = 0; r.wrst = 1;
            end
            tbl_px[i] = sat16(x + vx); tbl_py[i] = sat16(y + vy);
            tbl_vx[i] = vx; tbl_vy[i] = vy;
            r.seen = n[6:0];
        end
        r.px = tbl_px[i][15:0]; r.py = tbl_py[i][15:0];
        r.vx = tbl_vx[i][15:0]; r.vy = tbl_vy[i][15:0];
        return r;
    endfunction

    // result checker and receiver stall pattern
    always @(posedge aclk) begin
        flock_result_t got, exp_r;
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_entry_index, m_new_pos_x, m_new_pos_y, m_new_vel_x,
                       m_new_vel_y, m_neighbours_seen, m_wall_reset};
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %p", got);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", exp_r, got);
                    end
                end
            end
            // stall in phases: long open stretches, then choppy ones
            if (cycles[11:10] == 2'b00) m_ready <= 1;
            else if (cycles[11:10] == 2'b01) m_ready <= ($urandom_range(0, 3) != 0);
            else m_ready <= ($urandom_range(0, 1) != 0);
        end
    end

    task automatic send_beat(logic [1:0] fn, logic [5:0] i, logic signed [15:0] a,
                             logic signed [15:0] b, logic signed [15:0] c,
                             logic signed [15:0] d);
        int gap_cycles;
        if (burst_on) begin
            if (gap_left == 0) begin
                gap_left = $urandom_range(1, 12);
                gap_cycles = $urandom_range(0, 6);
                if (gap_cycles != 0) begin
                    s_valid <= 0;
                    repeat (gap_cycles) @(posedge aclk);
                end
            end
            gap_left--;
        end
        s_valid <= 1;
        s_func <= fn; s_boid_index <= i;
        s_load_pos_x <= a; s_load_pos_y <= b; s_load_vel_x <= c; s_load_vel_y <= d;
        expected_q.push_back(flock_step(fn, i, a, b, c, d));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_valid <= 0;
        while (expected_q.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] a, logic [15:0] v);
        cfg_we <= 1; cfg_addr <= a; cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        @(posedge aclk);
        case (a)
            REG_BOID_COUNT:     r_count = v[6:0];
            REG_AVOID_DISTANCE: r_avoid = v[14:0];
            REG_CENTER_RANGE:   r_range = v[14:0];
            REG_CENTER_GAIN:    r_cgain = v;
            REG_FOLLOW_GAIN:    r_fgain = v;
            REG_AVOID_GAIN:     r_again = v;
            REG_MAX_SPEED:      r_vmax = v[14:0];
            default:            r_vmin = v[14:0];
        endcase
    endtask

    task automatic write_all(int cnt, int ad, int cr, int cg, int fg, int ag,
                             int vmax, int vmin);
        write_reg(REG_BOID_COUNT, 16'(cnt));
        write_reg(REG_AVOID_DISTANCE, 16'(ad));
        write_reg(REG_CENTER_RANGE, 16'(cr));
        write_reg(REG_CENTER_GAIN, 16'(cg));
        write_reg(REG_FOLLOW_GAIN, 16'(fg));
        write_reg(REG_AVOID_GAIN, 16'(ag));
        write_reg(REG_MAX_SPEED, 16'(vmax));
        write_reg(REG_MIN_SPEED, 16'(vmin));
    endtask

    // positions mostly inside the arena, some near and beyond the walls
    function automatic logic signed [15:0] rand_pos();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(7900, 10500) * ($urandom_range(0, 1) ? 1 : -1));
            default: return 16'($signed($urandom_range(0, 16000)) - 8000);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_vel();
        case ($urandom_range(0, 7))
            0:       return 16'($urandom);
            1:       return 0;
            default: return 16'($signed($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    task automatic load_table();
        for (int i = 0; i < NB; i++)
            send_beat(FUNC_LOAD, 6'(i), rand_pos(), rand_pos(), rand_vel(), rand_vel());
    endtask

    task automatic test_directed();
        // field extremes on load and read, unused code 3 as read
        send_beat(FUNC_LOAD, 0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_beat(FUNC_LOAD, 63, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_beat(FUNC_READ, 0, 0, 0, 0, 0);
        send_beat(2'd3, 63, 16'shffff, 16'shffff, 16'shffff, 16'shffff);
        // updates from beyond the walls: position reset, extreme velocity
        send_beat(FUNC_UPDATE, 0, 0, 0, 0, 0);
        send_beat(FUNC_UPDATE, 63, 0, 0, 0, 0);
        // zero speed boid alone
        send_beat(FUNC_LOAD, 1, 0, 0, 0, 0);
        drain();
        write_all(2, 0, 0, 0, 0, 0, 82, 16);
        send_beat(FUNC_LOAD, 0, 16'sd2000, 0, 0, 0);
        send_beat(FUNC_UPDATE, 1, 0, 0, 0, 0);
        // boid count zero: nothing scanned
        drain();
        write_reg(REG_BOID_COUNT, 0);
        send_beat(FUNC_LOAD, 1, 16'sd100, 16'sd100, 16'sd3, 16'sd4);
        send_beat(FUNC_UPDATE, 1, 0, 0, 0, 0);
        // count above the table size
        drain();
        write_all(127, 32767, 32767, 65535, 65535, 65535, 32767, 32767);
        load_table();
        send_beat(FUNC_UPDATE, 5, 0, 0, 0, 0);
        send_beat(FUNC_UPDATE, 40, 0, 0, 0, 0);
        drain();
    endtask

    task automatic random_phase(int cnt, int ad, int cr, int cg, int fg, int ag,
                                int vmax, int vmin, int items);
        write_all(cnt, ad, cr, cg, fg, ag, vmax, vmin);
        burst_on = $urandom_range(0, 3) != 0;
        for (int k = 0; k < items; k++) begin
            case ($urandom_range(0, 9))
                0, 1:    send_beat(FUNC_LOAD, 6'($urandom_range(0, NB - 1)), rand_pos(),
                                   rand_pos(), rand_vel(), rand_vel());
                2:       send_beat($urandom_range(0, 1) ? FUNC_READ : 2'd3,
                                   6'($urandom_range(0, NB - 1)), 16'($urandom),
                                   16'($urandom), 16'($urandom), 16'($urandom));
                default: send_beat(FUNC_UPDATE, 6'($urandom_range(0, NB - 1)),
                                   16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
            endcase
        end
        drain();
        burst_on = 1;
    endtask

    task automatic test_random();
        random_phase(64, 410, 1638, 33, 3277, 3277, 82, 16, 300);
        random_phase(16, 1000, 4000, 8000, 20000, 10000, 300, 50, 250);
        random_phase(1, 0, 32767, 0, 0, 0, 0, 0, 150);
        random_phase($urandom_range(1, 64), $urandom_range(0, 32767),
                     $urandom_range(0, 32767), $urandom, $urandom, $urandom,
                     $urandom_range(0, 32767), $urandom_range(0, 32767), 250);
        random_phase(64, 32767, 32767, 65535, 65535, 65535, 32767, 0, 150);
        random_phase(40, 800, 3000, 500, 6000, 6000, 120, 120, 200);
    endtask

    initial begin
        aresetn = 0;
        s_valid = 0; s_func = FUNC_READ; s_boid_index = 0;
        s_load_pos_x = 0; s_load_pos_y = 0; s_load_vel_x = 0; s_load_vel_y = 0;
        cfg_we = 0; cfg_addr = REG_BOID_COUNT; cfg_wdata = 0;
        mismatches = 0; gap_left = 0; burst_on = 1;
        r_count = 64; r_avoid = 410; r_range = 1638; r_cgain = 33;
        r_fgain = 3277; r_again = 3277; r_vmax = 82; r_vmin = 16;
        for (int i = 0; i < NB; i++) begin
            tbl_px[i] = 0; tbl_py[i] = 0; tbl_vx[i] = 0; tbl_vy[i] = 0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // every entry written first so no scan touches an unwritten one
        load_table();
        drain();
        test_directed();
        test_random();
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
